[rtl/slwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwm_pkg
// Shared types, constants and helpers for the LIKE pattern matcher.
// ----------------------------------------------------------------------------
package slwm_pkg;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int LEN_W       = 6;
	localparam int CHAR_W      = 8;
	localparam int CHAR_REGS   = 4;
	localparam int CHARS_PER_REG = CFG_DATA_W / CHAR_W;

	localparam logic [CHAR_W-1:0] PCT_CHAR = 8'h25;
	localparam logic [CHAR_W-1:0] ANY_CHAR = 8'h5F;
	localparam logic [CHAR_W-1:0] LOWER_A  = 8'h61;
	localparam logic [CHAR_W-1:0] LOWER_Z  = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LENGTH  = 3'd0,
		REG_PATTERN_CHARS_0 = 3'd1,
		REG_PATTERN_CHARS_1 = 3'd2,
		REG_PATTERN_CHARS_2 = 3'd3,
		REG_PATTERN_CHARS_3 = 3'd4
	} cfg_reg_t;

	// per-beat flags carried through the classify queue
	typedef struct packed {
		logic last;
		logic no_byte;
	} item_flags_t;

	localparam int FLAGS_W = $bits(item_flags_t);

	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		if (c inside {[LOWER_A:LOWER_Z]}) begin
			return c - CASE_GAP;
		end
		return c;
	endfunction

endpackage

[rtl/slwm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwm_front
// Accepts text beats and classifies the byte against every pattern position.
// ----------------------------------------------------------------------------
module slwm_front #(
	parameter int PATTERN_MAX = 32
) (
	input  logic                                        push,
	input  logic                                        q_full,
	input  logic [slwm_pkg::CHAR_W-1:0]                 text_char,
	input  logic                                        is_last,
	input  logic                                        is_empty,
	input  logic [PATTERN_MAX-1:0][slwm_pkg::CHAR_W-1:0] pat,
	output logic                                        q_push,
	output slwm_pkg::item_flags_t                       flags,
	output logic [PATTERN_MAX-1:0]                      hit
);
	import slwm_pkg::*;

	logic [CHAR_W-1:0] text_fold;

	assign q_push    = push && !q_full;
	assign text_fold = fold_case(text_char);

	always_comb begin
		flags.last    = is_last;
		flags.no_byte = is_empty;
	end

	// '_' matches anything; other bytes compare with case folded
	always_comb begin
		for (int j = 0; j < PATTERN_MAX; j++) begin
			hit[j] = (pat[j] == ANY_CHAR) || (fold_case(pat[j]) == text_fold);
		end
	end

endmodule

[rtl/slwm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwm_queue
// Small register queue between the classify front and the row update back.
// ----------------------------------------------------------------------------
module slwm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] din,
	output logic             q_full,
	input  logic             rd,
	output logic [WIDTH-1:0] dout,
	output logic             q_empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign q_full  = (count_q == FULL_CNT);
	assign q_empty = (count_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/slwm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwm_back
// Updates the reach row one beat per cycle, barring a result stall, and holds the match result.
// ----------------------------------------------------------------------------
module slwm_back #(
	parameter int PATTERN_MAX = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               restart,
	input  logic [PATTERN_MAX-1:0]             pct,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]   used_len,
	input  logic                               q_empty,
	input  slwm_pkg::item_flags_t              flags,
	input  logic [PATTERN_MAX-1:0]             hit,
	output logic                               q_pop,
	input  logic                               pop,
	output logic                               empty,
	output logic                               matched
);
	import slwm_pkg::*;

	localparam int RW = PATTERN_MAX + 1;

	logic [RW-1:0] row_q, rz_q, row_old, row_new, row_pick;
	logic [RW-1:0] base, prop;
	logic          at_start_q, out_valid_q, matched_q, out_room;

	// carry style prefix: g[j] |= p[j] & g[j-1], log depth
	function automatic logic [RW-1:0] prefix_or(input logic [RW-1:0] g_in,
	                                            input logic [RW-1:0] p_in);
		logic [RW-1:0] g, p, g_nx, p_nx;
		g = g_in;
		p = p_in;
		for (int d = 1; d < RW; d = d * 2) begin
			g_nx = g;
			p_nx = p;
			for (int j = d; j < RW; j++) begin
				g_nx[j] = g[j] | (p[j] & g[j-d]);
				p_nx[j] = p[j] & p[j-d];
			end
			g = g_nx;
			p = p_nx;
		end
		return g;
	endfunction

	assign prop     = {pct, 1'b0};
	assign row_old  = at_start_q ? rz_q : row_q;

	always_comb begin
		base[0] = 1'b0;
		for (int j = 1; j < RW; j++) begin
			if (pct[j-1]) begin
				base[j] = row_old[j] | row_old[j-1];
			end else if (hit[j-1]) begin
				base[j] = row_old[j-1];
			end else begin
				base[j] = 1'b0;
			end
		end
	end

	assign row_new  = prefix_or(base, prop);
	assign row_pick = flags.no_byte ? row_old : row_new;

	assign out_room = !out_valid_q || pop;
	assign q_pop    = !q_empty && (!flags.last || out_room);
	assign empty    = !out_valid_q;
	assign matched  = matched_q;

	// row zero tracks config; registered, it settles in the cycle after the config registers change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rz_q <= RW'(1);
		end else begin
			rz_q <= prefix_or(RW'(1), prop);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && !flags.last && !flags.no_byte) begin
			row_q <= row_new;
		end
		if (q_pop && flags.last) begin
			matched_q <= row_pick[used_len];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (restart || (q_pop && flags.last)) begin
				at_start_q <= 1'b1;
			end else if (q_pop && !flags.no_byte) begin
				at_start_q <= 1'b0;
			end
			if (q_pop && flags.last) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/sql_like_wildcard_matcher.sv]
`timescale 1ns / 1ps
// Result path: the last beat of a text is written into the queue, then the
//   back end pops it and registers the match result.
// Throughput: one beat per cycle unless results back up, set by the combinational
//   prefix update of the reach row in the back end; a two-entry queue decouples front and back.
// Reset: config cleared to zero, row at row zero, queue and result slot empty.
// ----------------------------------------------------------------------------
// sql_like_wildcard_matcher
// Case-insensitive LIKE matcher ('%' and '_') over a streamed byte text.
// ----------------------------------------------------------------------------
module sql_like_wildcard_matcher #(
	parameter int PATTERN_MAX = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [slwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [slwm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                push,
	output logic                                full,
	input  logic [slwm_pkg::CHAR_W-1:0]         text_char,
	input  logic                                is_last,
	input  logic                                is_empty,
	output logic                                empty,
	input  logic                                pop,
	output logic                                matched
);
	import slwm_pkg::*;

	localparam int NW      = $clog2(PATTERN_MAX + 1);
	localparam int Q_W     = FLAGS_W + PATTERN_MAX;
	localparam int Q_DEPTH = 2;

	logic [LEN_W-1:0]                   len_q;
	logic [CHAR_REGS-1:0][CFG_DATA_W-1:0] chars_q;
	logic [PATTERN_MAX-1:0][CHAR_W-1:0] pat;
	logic [PATTERN_MAX-1:0]             pct;
	logic [NW-1:0]                      used_len;
	logic                               restart;

	logic                               q_push, q_pop, q_empty;
	item_flags_t                        f_flags, b_flags;
	logic [PATTERN_MAX-1:0]             f_hit, b_hit;

	// config registers; a write to a listed register restarts the text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			chars_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_LENGTH:  len_q      <= cfg_wdata[LEN_W-1:0];
				REG_PATTERN_CHARS_0: chars_q[0] <= cfg_wdata;
				REG_PATTERN_CHARS_1: chars_q[1] <= cfg_wdata;
				REG_PATTERN_CHARS_2: chars_q[2] <= cfg_wdata;
				REG_PATTERN_CHARS_3: chars_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_index)
			REG_PATTERN_LENGTH, REG_PATTERN_CHARS_0, REG_PATTERN_CHARS_1,
			REG_PATTERN_CHARS_2, REG_PATTERN_CHARS_3: restart = cfg_we;
			default: restart = 1'b0;
		endcase
	end

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pat
		assign pat[j] = chars_q[j / CHARS_PER_REG][(j % CHARS_PER_REG) * CHAR_W +: CHAR_W];
		assign pct[j] = (pat[j] == PCT_CHAR);
	end

	// length saturates at the pattern capacity
	assign used_len = (len_q > LEN_W'(PATTERN_MAX)) ? NW'(PATTERN_MAX) : len_q[NW-1:0];

	slwm_front #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_front (
		.push      (push),
		.q_full    (full),
		.text_char (text_char),
		.is_last   (is_last),
		.is_empty  (is_empty),
		.pat       (pat),
		.q_push    (q_push),
		.flags     (f_flags),
		.hit       (f_hit)
	);

	slwm_queue #(
		.WIDTH (Q_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.din     ({f_flags, f_hit}),
		.q_full  (full),
		.rd      (q_pop),
		.dout    ({b_flags, b_hit}),
		.q_empty (q_empty)
	);

	slwm_back #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.pct      (pct),
		.used_len (used_len),
		.q_empty  (q_empty),
		.flags    (b_flags),
		.hit      (b_hit),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.matched  (matched)
	);

	a_pop_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back end dequeued from an empty queue");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && b_flags.last) |=> !empty)
		else $error("last beat did not produce a result");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !q_empty)
		else $error("accepted beat missing from queue");

endmodule

[sim/sql_like_wildcard_matcher_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_like_wildcard_matcher_tb
// Streams byte texts through the LIKE matcher under a series of patterns and
// compares every match bit against a bit-parallel row predictor kept in step
// with each accepted beat. Both queue sides idle at random; long result
// stalls force the input to back up.
// ----------------------------------------------------------------------------
module sql_like_wildcard_matcher_tb;
	import slwm_pkg::*;

	localparam int ITEM_TARGET    = 1650;
	localparam int CALM_TAIL      = 250;
	localparam int SETTLE_CYCLES  = 6;
	localparam int LONG_STALL     = 80;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SPARE_REG_LO   = int'(REG_PATTERN_CHARS_3) + 1;
	localparam int SPARE_REG_HI   = (1 << CFG_INDEX_W) - 1;

	class like_match_predictor;
		logic [LEN_W-1:0]      len_reg;
		logic [CFG_DATA_W-1:0] chars_reg [CHAR_REGS];
		logic [32:0]           reach;
		bit                    expected_matches [$];
		int                    mismatches;
		int                    matches_checked;
		int                    matches_true;

		function new();
			len_reg = '0;
			foreach (chars_reg[i]) chars_reg[i] = '0;
			mismatches = 0;
			matches_checked = 0;
			matches_true = 0;
			reach = row_zero();
		endfunction

		function int used_len();
			return (len_reg > 32) ? 32 : int'(len_reg);
		endfunction

		function logic [CHAR_W-1:0] pat_byte(int j);
			return chars_reg[j / CHARS_PER_REG][(j % CHARS_PER_REG) * CHAR_W +: CHAR_W];
		endfunction

		function logic [CHAR_W-1:0] upcase(logic [CHAR_W-1:0] c);
			return (c >= LOWER_A && c <= LOWER_Z) ? (c & ~CASE_GAP) : c;
		endfunction

		// bit j set: pattern prefix of length j matches the empty text
		function logic [32:0] row_zero();
			logic [32:0] row;
			row = 33'd1;
			for (int j = 0; j < used_len(); j++) begin
				if (pat_byte(j) != PCT_CHAR) break;
				row[j+1] = 1'b1;
			end
			return row;
		endfunction

		function logic [32:0] advance(logic [32:0] prev, logic [CHAR_W-1:0] c);
			logic [32:0]       nxt;
			logic [CHAR_W-1:0] p;
			nxt = '0;
			for (int j = 1; j <= used_len(); j++) begin
				p = pat_byte(j - 1);
				if (p == PCT_CHAR) begin
					nxt[j] = nxt[j-1] | prev[j] | prev[j-1];
				end else if (p == ANY_CHAR || upcase(p) == upcase(c)) begin
					nxt[j] = prev[j-1];
				end
			end
			return nxt;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PATTERN_LENGTH: len_reg = data[LEN_W-1:0];
				REG_PATTERN_CHARS_0, REG_PATTERN_CHARS_1,
				REG_PATTERN_CHARS_2, REG_PATTERN_CHARS_3: begin
					chars_reg[idx - REG_PATTERN_CHARS_0] = data;
				end
				default: return;
			endcase
			reach = row_zero();
		endfunction

		function void note_beat(logic [CHAR_W-1:0] c, logic last, logic no_byte);
			if (!no_byte) reach = advance(reach, c);
			if (last) begin
				expected_matches.push_back(reach[used_len()]);
				reach = row_zero();
			end
		endfunction

		function void check_match(logic got);
			bit want;
			if (expected_matches.size() == 0) begin
				$error("matched: no result expected, actual %0b", got);
				mismatches++;
				return;
			end
			want = expected_matches.pop_front();
			matches_checked++;
			if (want) matches_true++;
			if (got !== want) begin
				$error("matched: expected %0b, actual %0b", want, got);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_matches.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   push;
	logic                   full;
	logic [CHAR_W-1:0]      text_char;
	logic                   is_last;
	logic                   is_empty;
	logic                   empty;
	logic                   pop;
	logic                   matched;

	like_match_predictor pred = new();

	logic [CHAR_W-1:0] pat_buf [32];
	logic [CHAR_W-1:0] text_q [$];
	int                beats_sent;
	int                texts_sent;
	int                settings_used;
	int                long_stall_reqs;
	int                stalls_done = 0;
	int                idle_cycles = 0;
	bit                calm;

	sql_like_wildcard_matcher u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.text_char (text_char),
		.is_last   (is_last),
		.is_empty  (is_empty),
		.empty     (empty),
		.pop       (pop),
		.matched   (matched)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cycles without a beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no beat for %0d cycles", idle_cycles);
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : result_sink
		int gap;
		gap = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) pred.check_match(matched);
			if (gap > 0) begin
				gap--;
				pop <= 1'b0;
			end else if (stalls_done < long_stall_reqs) begin
				stalls_done++;
				gap = LONG_STALL;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(3) == 0) begin
				gap = $urandom_range(3);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic drive_beat(logic [CHAR_W-1:0] c, logic last, logic no_byte);
		if (!calm && $urandom_range(4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push      <= 1'b1;
		text_char <= c;
		is_last   <= last;
		is_empty  <= no_byte;
		@(posedge clk);
		while (full) @(posedge clk);
		pred.note_beat(c, last, no_byte);
		beats_sent++;
		if (last) texts_sent++;
	endtask

	// wait for all results, then let in-flight beats drain
	task automatic settle();
		push <= 1'b0;
		while (pred.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_we high; caller lowers it after the last write
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		pred.write_reg(idx, data);
	endtask

	task automatic load_pattern(logic [LEN_W-1:0] len);
		logic [CFG_DATA_W-1:0] word;
		write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
		for (int r = 0; r < CHAR_REGS; r++) begin
			for (int b = 0; b < CHARS_PER_REG; b++) word[b*CHAR_W +: CHAR_W] = pat_buf[r*8 + b];
			write_reg(cfg_reg_t'(int'(REG_PATTERN_CHARS_0) + r), word);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic void fill_pattern(string s);
		for (int i = 0; i < 32; i++) pat_buf[i] = (i < s.len()) ? s[i] : CHAR_W'($urandom);
	endfunction

	task automatic send_str(string s);
		for (int i = 0; i < s.len(); i++) drive_beat(s[i], i == s.len() - 1, 1'b0);
	endtask

	// sends text_q as one text, with stray no-byte beats mixed in
	task automatic send_text();
		bit tail_empty;
		tail_empty = (text_q.size() == 0) || ($urandom_range(7) == 0);
		foreach (text_q[i]) begin
			if ($urandom_range(11) == 0) drive_beat(CHAR_W'($urandom), 1'b0, 1'b1);
			drive_beat(text_q[i], !tail_empty && i == text_q.size() - 1, 1'b0);
		end
		if (tail_empty) drive_beat(CHAR_W'($urandom), 1'b1, 1'b1);
	endtask

	function automatic logic [CHAR_W-1:0] flip_case(logic [CHAR_W-1:0] c);
		if ((c | CASE_GAP) >= LOWER_A && (c | CASE_GAP) <= LOWER_Z && $urandom_range(1))
			return c ^ CASE_GAP;
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] pick_pattern_byte();
		case ($urandom_range(9))
			0, 1, 2: return PCT_CHAR;
			3, 4:    return ANY_CHAR;
			5, 6, 7: return flip_case(LOWER_A + CHAR_W'($urandom_range(3)));
			8:       return 8'h00;
			default: return CHAR_W'($urandom);
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] pick_text_byte();
		case ($urandom_range(7))
			0:       return CHAR_W'($urandom);
			1:       return $urandom_range(1) ? PCT_CHAR : ANY_CHAR;
			default: return flip_case(LOWER_A + CHAR_W'($urandom_range(3)));
		endcase
	endfunction

	task automatic roll_pattern();
		logic [LEN_W-1:0] len;
		int               sel;
		sel = $urandom_range(9);
		if (sel < 7) len = LEN_W'($urandom_range(8));
		else if (sel < 9) len = LEN_W'($urandom_range(32, 9));
		else len = LEN_W'($urandom_range(63, 33));
		for (int i = 0; i < 32; i++)
			pat_buf[i] = (i < len) ? pick_pattern_byte() : CHAR_W'($urandom);
		load_pattern(len);
	endtask

	// mostly texts shaped by the pattern, some loose and some raw noise
	function automatic void build_text(int plen);
		int sel;
		text_q.delete();
		sel = $urandom_range(19);
		if (sel < 12) begin
			for (int j = 0; j < plen; j++) begin
				if (pat_buf[j] == PCT_CHAR) begin
					repeat ($urandom_range(3)) text_q.push_back(pick_text_byte());
				end else if (pat_buf[j] == ANY_CHAR) begin
					text_q.push_back(CHAR_W'($urandom));
				end else begin
					text_q.push_back(flip_case(pat_buf[j]));
				end
			end
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(2))
					0: if (text_q.size() != 0) void'(text_q.pop_back());
					1: if (text_q.size() != 0)
						text_q[$urandom_range(text_q.size() - 1)] = pick_text_byte();
					default: text_q.push_back(pick_text_byte());
				endcase
			end
		end else if (sel < 17) begin
			repeat ($urandom_range(8)) text_q.push_back(pick_text_byte());
		end else begin
			repeat ($urandom_range(6)) text_q.push_back(CHAR_W'($urandom));
		end
	endfunction

	initial begin : stimulus
		int plen;
		int phase;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_wdata   <= '0;
		push        <= 1'b0;
		text_char   <= '0;
		is_last     <= 1'b0;
		is_empty    <= 1'b0;
		beats_sent = 0;
		texts_sent = 0;
		settings_used = 1;
		long_stall_reqs = 0;
		calm = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern is empty: only the empty text matches
		drive_beat(8'h00, 1'b1, 1'b1);
		send_str("x");

		// leading run of '%', wildcard and mixed case letters
		settle();
		fill_pattern("%%Ab_%");
		load_pattern(6);
		drive_beat(8'h00, 1'b1, 1'b1);
		send_str("aBz");
		send_str("AB");
		drive_beat(8'hFF, 1'b0, 1'b0);
		drive_beat(8'h00, 1'b0, 1'b0);
		drive_beat(8'hA5, 1'b0, 1'b1);
		drive_beat("a", 1'b0, 1'b0);
		drive_beat("b", 1'b0, 1'b0);
		drive_beat(8'h00, 1'b1, 1'b0);

		// length saturates; whole pattern is '%'
		settle();
		fill_pattern("%%%%%%%%%%%%%%%%%%%%%%%%%%%%%%%%");
		load_pattern(63);
		drive_beat(8'hFF, 1'b1, 1'b1);
		drive_beat(8'hFF, 1'b0, 1'b0);
		drive_beat(8'h80, 1'b1, 1'b0);

		// spare register index is ignored
		settle();
		write_reg(CFG_INDEX_W'(SPARE_REG_HI), '1);
		cfg_we <= 1'b0;
		send_str("x");

		// a register write restarts a text in progress
		drive_beat("q", 1'b0, 1'b0);
		settle();
		fill_pattern("_");
		pat_buf[1] = 8'h00;
		load_pattern(2);
		drive_beat("z", 1'b0, 1'b0);
		drive_beat(8'h00, 1'b1, 1'b0);

		phase = 0;
		while (beats_sent < ITEM_TARGET) begin
			settle();
			if (beats_sent > ITEM_TARGET - CALM_TAIL) calm = 1'b1;
			if ($urandom_range(5) == 0) begin
				write_reg(CFG_INDEX_W'($urandom_range(SPARE_REG_HI, SPARE_REG_LO)),
					{$urandom, $urandom});
			end
			if (phase > 0 && $urandom_range(3) == 0) begin
				// length only; chars stay from the last setting
				write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'($urandom_range(63)));
				cfg_we <= 1'b0;
				settings_used++;
				for (int i = 0; i < 32; i++)
					pat_buf[i] = pred.chars_reg[i / CHARS_PER_REG][(i % CHARS_PER_REG) * CHAR_W +: CHAR_W];
			end else begin
				roll_pattern();
			end
			plen = pred.used_len();
			if (phase == 2 || phase == 9) begin
				// results back up while the sender keeps going
				long_stall_reqs++;
				repeat (40) begin
					build_text(plen);
					while (text_q.size() > 1) void'(text_q.pop_back());
					send_text();
				end
			end else begin
				repeat ($urandom_range(16, 4)) begin
					build_text(plen);
					send_text();
				end
			end
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(3, 1)) drive_beat(pick_text_byte(), 1'b0, 1'b0);
			end
			phase++;
		end

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d beats in %0d texts over %0d pattern settings;",
			beats_sent, texts_sent, settings_used);
		$display("checked %0d match bits, %0d of them true.",
			pred.matches_checked, pred.matches_true);
		if (pred.mismatches == 0 && pred.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
